>>> rtl/core/sts_pkg.sv
// shared types and constants for the sorted table binary search unit
// no dependencies
package sts_pkg;

    localparam int DEPTH       = 1024;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ENTRY_W     = 10;
    localparam int ADDR_W      = 64;
    localparam int CFG_W       = 11;
    localparam int POS_W       = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W   = 144;
    localparam int M_TDATA_W   = 16;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                op;
        logic [ENTRY_W-1:0] index;
        logic [ADDR_W-1:0]  data;
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_MID,
        ST_RESULT
    } state_t;

endpackage

>>> rtl/core/sts_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sts_front.sv
// front end: accepts stream requests and classifies them into commands
// depends on sts_pkg
module sts_front
    import sts_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 push_valid,
    input  logic                 push_ready,
    output cmd_t                 push_data
);

    logic [ENTRY_W-1:0] index;
    logic [ADDR_W-1:0]  value;
    logic [ADDR_W-1:0]  address;

    assign index   = s_tdata[ENTRY_W-1:0];
    assign value   = s_tdata[ENTRY_W+ADDR_W-1:ENTRY_W];
    assign address = s_tdata[ENTRY_W+2*ADDR_W-1:ENTRY_W+ADDR_W];

    always_comb
    begin
        push_data.op    = op_t'(s_tuser);
        push_data.index = index;
        case (op_t'(s_tuser))
            OP_LOAD:   push_data.data = value;
            OP_SEARCH: push_data.data = address;
            default:   push_data.data = address;
        endcase
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

>>> rtl/core/sts_fifo.sv
// short command queue between front and back end
// depends on sts_pkg
module sts_fifo
    import sts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/sts_back.sv
// back end: table loads and the binary search sequencer, with output register
// depends on sts_pkg and sts_ram
module sts_back
    import sts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CNT_W-1:0]     count,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  cmd_t                 pop_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [CNT_W-1:0]   low_reg;
    logic [CNT_W-1:0]   low_next;
    logic [CNT_W-1:0]   high_reg;
    logic [CNT_W-1:0]   high_next;
    logic [IDX_W-1:0]   mid_reg;
    logic [IDX_W-1:0]   mid_next;
    logic               found_reg;
    logic               found_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_found_reg;
    logic               out_found_next;
    logic [POS_W-1:0]   out_pos_reg;
    logic [POS_W-1:0]   out_pos_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [KEY_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [KEY_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]  key_ext;
    logic               addr_lt;
    logic               addr_gt;
    logic               pop_fire;
    logic               out_free;
    logic               index_ok;
    logic [CNT_W-1:0]   mid_lo_next;
    logic [CNT_W-1:0]   mid_hi_next;
    logic [CNT_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid_calc;
    logic [CNT_W-1:0]   last_idx;

    sts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign key_ext  = ADDR_W'(ram_rdata);
    assign addr_lt  = addr_reg < key_ext;
    assign addr_gt  = addr_reg > key_ext;
    assign pop_fire = pop_valid && pop_ready;
    assign out_free = !out_valid_reg || m_tready;
    assign index_ok = (32'(pop_data.index) < DEPTH);
    assign last_idx = count - 1'b1;

    // next bounds of the halving range while probing
    always_comb
    begin
        if (state_reg == ST_MID)
        begin
            if (addr_lt)
            begin
                mid_lo_next = low_reg;
                mid_hi_next = CNT_W'(mid_reg);
            end
            else
            begin
                mid_lo_next = CNT_W'(mid_reg) + 1'b1;
                mid_hi_next = high_reg;
            end
        end
        else
        begin
            mid_lo_next = '0;
            mid_hi_next = count;
        end
        mid_sum  = {1'b0, mid_lo_next} + {1'b0, mid_hi_next};
        mid_calc = mid_sum[IDX_W:1];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && pop_data.op == OP_SEARCH)
                begin
                    state_next = (count == '0) ? ST_RESULT : ST_FIRST;
                end
            end
            ST_FIRST:  state_next = addr_lt ? ST_RESULT : ST_LAST;
            ST_LAST:   state_next = addr_gt ? ST_RESULT : ST_MID;
            ST_MID:
            begin
                if (!addr_lt && !addr_gt)
                begin
                    state_next = ST_RESULT;
                end
                else if (!(mid_lo_next < mid_hi_next))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: state_next = out_free ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop_ready      = (state_reg == ST_IDLE);
        ram_we         = 1'b0;
        ram_waddr      = IDX_W'(pop_data.index);
        ram_wdata      = pop_data.data[KEY_W-1:0];
        ram_re         = 1'b0;
        ram_raddr      = '0;
        addr_next      = addr_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_fire)
                begin
                    addr_next  = pop_data.data;
                    found_next = 1'b0;
                    pos_next   = POS_W'(count);
                    if (pop_data.op == OP_LOAD)
                    begin
                        ram_we = index_ok;
                    end
                    else if (count != '0)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                    end
                end
            end
            ST_FIRST:
            begin
                if (!addr_lt)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = last_idx[IDX_W-1:0];
                end
            end
            ST_LAST:
            begin
                if (!addr_gt)
                begin
                    low_next  = '0;
                    high_next = count;
                    mid_next  = mid_calc;
                    ram_re    = 1'b1;
                    ram_raddr = mid_calc;
                end
            end
            ST_MID:
            begin
                if (!addr_lt && !addr_gt)
                begin
                    found_next = 1'b1;
                    pos_next   = POS_W'(mid_reg);
                end
                else
                begin
                    low_next  = mid_lo_next;
                    high_next = mid_hi_next;
                    mid_next  = mid_calc;
                    ram_re    = 1'b1;
                    ram_raddr = mid_calc;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_pos_next   = pos_reg;
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        mid_reg       <= mid_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = M_TDATA_W'(out_pos_reg);

endmodule

>>> rtl/core/sorted_table_binary_search_unit.sv
// sorted table binary search unit: load requests fill the table, search requests report
// found and position; a search on an empty table goes straight to the result, a bound
// miss ends once the first or last entry is read, else up to 11 halving probes follow
// (one table read per cycle); a search holds the back end until its result enters the
// output register, while a load leaves it idle; requests queue two deep ahead of the back end
// reset clears control and the entry count; table contents undefined until loaded
module sorted_table_binary_search_unit
    import sts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,   // entries_in_use
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // entry_index, entry_value, search_address, zero pad
    input  logic                 s_tuser,    // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // position, zero pad
    output logic                 m_tuser     // found
);

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] cfg_next;
    logic [CNT_W-1:0] count;
    logic             push_valid;
    logic             push_ready;
    cmd_t             push_data;
    logic             pop_valid;
    logic             pop_ready;
    cmd_t             pop_data;

    assign cfg_ready = 1'b1;
    assign cfg_next  = (cfg_valid && cfg_ready) ? cfg_data : cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // saturate the count to the table depth
    assign count = (32'(cfg_reg) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cfg_reg);

    sts_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sts_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .count     (count),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> tb/tb.sv
// testbench for sorted_table_binary_search_unit: directed table then random load/search phases
// results checked in order against fixed directed answers or a behavioral binary search over a local copy of the table
// depends on rtl/core/sts_pkg.sv and rtl/core/sorted_table_binary_search_unit.sv
`timescale 1ns / 100ps

module tb;
    import sts_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int SETTLE_CYCLES   = 64;
    localparam int N_DIRECTED      = 25;
    localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] position;
    } search_answer_t;

    typedef enum logic [1:0]
    {
        STEP_LOAD,
        STEP_SEARCH,
        STEP_COUNT
    } step_kind_t;

    // for a search, value is the address; for a count write, value is the count
    typedef struct packed
    {
        step_kind_t         kind;
        logic               check;
        logic               exp_found;
        logic [POS_W-1:0]   exp_pos;
        logic [ENTRY_W-1:0] idx;
        logic [KEY_W-1:0]   value;
    } directed_step_t;

    localparam directed_step_t DIRECTED_STEPS [N_DIRECTED] = '{
        '{STEP_SEARCH, 1, 0, 0, 0, 0},
        '{STEP_SEARCH, 1, 0, 0, 0, ALL_ONES},
        '{STEP_LOAD,   0, 0, 0, 0, 3},
        '{STEP_LOAD,   0, 0, 0, 1, 5},
        '{STEP_LOAD,   0, 0, 0, 2, 10},
        '{STEP_LOAD,   0, 0, 0, 3, 20},
        '{STEP_LOAD,   0, 0, 0, 4, 40},
        '{STEP_LOAD,   0, 0, 0, 5, 1000},
        '{STEP_LOAD,   0, 0, 0, 6, 64'hFFFF_FFFF_FFFF_FFFE},
        '{STEP_LOAD,   0, 0, 0, 7, ALL_ONES},
        '{STEP_LOAD,   0, 0, 0, 1023, ALL_ONES},
        '{STEP_LOAD,   0, 0, 0, 8, 0},
        '{STEP_COUNT,  0, 0, 0, 0, 8},
        '{STEP_SEARCH, 1, 0, 8, 0, 0},
        '{STEP_SEARCH, 1, 1, 0, 0, 3},
        '{STEP_SEARCH, 1, 1, 7, 0, ALL_ONES},
        '{STEP_SEARCH, 1, 1, 3, 0, 20},
        '{STEP_SEARCH, 1, 0, 8, 0, 7},
        '{STEP_SEARCH, 0, 0, 0, 0, 1001},
        '{STEP_COUNT,  0, 0, 0, 0, 1},
        '{STEP_SEARCH, 1, 1, 0, 0, 3},
        '{STEP_SEARCH, 1, 0, 1, 0, 4},
        '{STEP_SEARCH, 1, 0, 1, 0, 2},
        '{STEP_LOAD,   0, 0, 0, 0, 7},
        '{STEP_SEARCH, 1, 1, 0, 0, 7}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    logic [KEY_W-1:0]     key_table [DEPTH];
    logic [CFG_W-1:0]     entry_count = '0;
    search_answer_t       pending_answers [$];
    search_answer_t       oldest_answer;
    int                   error_count = 0;
    int                   accepted_requests = 0;
    int unsigned          sender_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;

    sorted_table_binary_search_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic search_answer_t predict_search(input logic [ADDR_W-1:0] addr);
        int n;
        int low;
        int high;
        int mid;
        search_answer_t ans;
        n = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
        ans.found = 1'b0;
        ans.position = POS_W'(n);
        if (n == 0 || addr < key_table[0] || addr > key_table[n-1])
            return ans;
        low = 0;
        high = n;
        while (low < high)
        begin
            mid = (low + high) >> 1;
            if (addr < key_table[mid])
                high = mid;
            else if (addr > key_table[mid])
                low = mid + 1;
            else
            begin
                ans.found = 1'b1;
                ans.position = POS_W'(mid);
                return ans;
            end
        end
        return ans;
    endfunction

    task automatic issue_request(input op_t op, input logic [ENTRY_W-1:0] idx,
        input logic [KEY_W-1:0] value, input logic [ADDR_W-1:0] addr,
        input bit fixed = 1'b0, input search_answer_t fixed_answer = '0);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({addr, value, idx});
        do @(posedge clk); while (!s_tready);
        accepted_requests++;
        if (op == OP_LOAD)
            key_table[idx] = value;
        else
            pending_answers.push_back(fixed ? fixed_answer : predict_search(addr));
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
    endtask

    task automatic set_entry_count(input logic [CFG_W-1:0] value);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        entry_count = value;
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected search result found=%0b position=%0d",
                         $time, m_tuser, m_tdata[POS_W-1:0]);
                error_count++;
            end
            else
            begin
                oldest_answer = pending_answers.pop_front();
                if (m_tuser !== oldest_answer.found ||
                    m_tdata[POS_W-1:0] !== oldest_answer.position)
                begin
                    $display("%0t: search mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                             $time, oldest_answer.found, oldest_answer.position,
                             m_tuser, m_tdata[POS_W-1:0]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        directed_step_t   step;
        int               base;
        int               phase;
        int               refill;
        int               new_count;
        int               live;
        int               batch;
        int               pick;
        int               hit;
        logic [KEY_W-1:0] span;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] probe;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            step = DIRECTED_STEPS[i];
            case (step.kind)
                STEP_LOAD:   issue_request(OP_LOAD, step.idx, step.value, '0);
                STEP_SEARCH: issue_request(OP_SEARCH, '0, '0, step.value, step.check,
                                           {step.exp_found, step.exp_pos});
                default:     set_entry_count(CFG_W'(step.value));
            endcase
        end

        base = accepted_requests;
        phase = 0;
        while (accepted_requests - base < RANDOM_REQUESTS)
        begin
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 81;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 81;
                end
                default:
                begin
                    sender_idle_pct = 23;
                    recv_stall_pct  = 23;
                end
            endcase

            // first phase fills the whole table so any count is legal afterwards
            refill = 0;
            batch = 100;
            if (phase == 0)
            begin
                refill = DEPTH;
                new_count = DEPTH;
            end
            else if (phase == 1)
                new_count = 2047;
            else if (phase == 2)
                new_count = DEPTH + 1;
            else
            begin
                pick = $urandom_range(0, 15);
                batch = $urandom_range(20, 60);
                if (pick == 0)
                    new_count = 0;
                else if (pick == 1)
                    new_count = $urandom_range(DEPTH, 2047);
                else
                begin
                    refill = (pick < 5) ? $urandom_range(1, 3) : $urandom_range(4, 64);
                    new_count = refill;
                end
            end

            // ascending keys, each in its own slice of a random range, with repeats
            if (refill > 0)
            begin
                span = (ALL_ONES >> $urandom_range(0, 63)) / KEY_W'(refill);
                if (span == 0)
                    span = 1;
                key = '0;
                for (int i = 0; i < refill; i++)
                begin
                    if (i == 0 || $urandom_range(0, 5) != 0)
                        key = KEY_W'(i) * span + rand_key() % span;
                    issue_request(OP_LOAD, ENTRY_W'(i), key, '0);
                    if ($urandom_range(0, 7) == 0)
                        issue_request(OP_SEARCH, '0, '0, rand_key());
                end
            end

            set_entry_count(CFG_W'(new_count));
            live = (new_count > DEPTH) ? DEPTH : new_count;

            for (int j = 0; j < batch; j++)
            begin
                if (phase == 3 && j == batch / 2)
                    wait_until_drained();
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    issue_request(OP_LOAD, ENTRY_W'($urandom_range(0, DEPTH - 1)), rand_key(), '0);
                else
                begin
                    probe = rand_key();
                    if (pick == 15)
                        probe = '0;
                    else if (pick == 16)
                        probe = ALL_ONES;
                    else if (live > 0 && pick != 19)
                    begin
                        hit = $urandom_range(0, live - 1);
                        if (pick <= 10)
                            probe = key_table[hit];
                        else if (pick <= 12)
                            probe = key_table[hit] + 1;
                        else if (pick <= 14)
                            probe = key_table[hit] - 1;
                        else if (pick == 17)
                            probe = key_table[0] - 1;
                        else
                            probe = key_table[live - 1] + 1;
                    end
                    issue_request(OP_SEARCH, '0, '0, probe);
                end
            end
            phase++;
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[sorted_table_binary_search_unit] OK");
        else
            $display("[sorted_table_binary_search_unit] ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("[sorted_table_binary_search_unit] ERROR");
        $finish;
    end

endmodule
